// ===== design/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and helpers of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_PAD80,
    ST_PADZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } round_vars_t;

  // Block buffer control: a byte-lane write at one word, or a schedule shift.
  // lane_en[j] enables bits [8j+7:8j].
  typedef struct packed {
    logic        wr;
    logic [3:0]  idx;
    logic [3:0]  lane_en;
    logic [31:0] data;
    logic        shift;
  } buf_ctrl_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LEN_FILL   = 6'd56;
  localparam logic [3:0] LEN_HI_IDX = 4'd14;
  localparam logic [3:0] LEN_LO_IDX = 4'd15;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ===== design/sha1_sched.sv =====
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer and message schedule window of the SHA-1 engine.
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                clk,
  input  sha1_pkg::buf_ctrl_t ctrl,
  output logic [31:0]         w_cur
);

  logic [31:0] blk [16];
  logic [31:0] w_new;

  assign w_new = sha1_pkg::rotl(blk[13] ^ blk[8] ^ blk[2] ^ blk[0], 1);
  assign w_cur = blk[0];

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      // slide the window: blk[0] is always the word of the current round
      for (int i = 0; i < 15; i++) begin
        blk[i] <= blk[i + 1];
      end
      blk[15] <= w_new;
    end else if (ctrl.wr) begin
      for (int j = 0; j < 4; j++) begin
        if (ctrl.lane_en[j]) begin
          blk[ctrl.idx][8*j +: 8] <= ctrl.data[8*j +: 8];
        end
      end
    end
  end

endmodule

// ===== design/sha1_round.sv =====
// ----------------------------------------------------------------------------
// sha1_round
// One SHA-1 compression round, shared across all 80 rounds of a block.
// ----------------------------------------------------------------------------
module sha1_round (
  input  sha1_pkg::round_vars_t vars,
  input  logic [31:0]           w,
  input  logic [6:0]            rnd,
  output sha1_pkg::round_vars_t vars_next
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = sha1_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = sha1_pkg::K2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1_pkg::K3;
    end
  end

  always_comb begin
    vars_next.a = sha1_pkg::rotl(vars.a, 5) + f + vars.e + k + w;
    vars_next.b = vars.a;
    vars_next.c = sha1_pkg::rotl(vars.b, 30);
    vars_next.d = vars.c;
    vars_next.e = vars.d;
  end

endmodule

// ===== design/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// Streaming SHA-1 engine: message words in, five digest words out.
// ----------------------------------------------------------------------------
// Each input transaction carries one big-endian message word with 0 to 4
// valid leading bytes (tuser); tlast ends the message. s_tready is high only
// while the engine is idle. A word is taken and then packed into the
// block buffer (in two parts when it straddles a buffer word); each full
// 64-byte block is compressed by 80 passes of the single round unit, and
// the result is then folded into the chaining value. The engine takes no
// new word until it is through with the last. On tlast the engine pads in
// the buffer, one word per cycle except while a block is compressed,
// compresses one or two more blocks and then presents the digest as five
// transactions, word 0 (most significant) first, tlast on word 4; it then
// restarts from the initial vector.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_word
  input  logic [2:0]  s_tuser,   // [2:0] valid_bytes
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // digest_last
);

  sha1_pkg::state_t      state, state_next;
  sha1_pkg::state_t      ret_state, ret_next;
  sha1_pkg::round_vars_t vars, vars_next;
  sha1_pkg::buf_ctrl_t   buf_ctrl;

  logic [31:0] chain [5];
  logic [63:0] msg_bits;
  logic [5:0]  fill;
  logic [6:0]  rnd;
  logic [31:0] data_reg;
  logic [2:0]  rem;
  logic [2:0]  pos;
  logic        last_reg;
  logic [2:0]  out_idx;
  logic [31:0] w_cur;

  logic [2:0]  in_count;
  logic [1:0]  lane_off;
  logic [2:0]  room;
  logic [2:0]  ins_k;
  logic [2:0]  rem_after;
  logic [5:0]  fill_ins;
  logic [5:0]  fill_pad;
  logic [5:0]  fill_word;
  logic [31:0] ins_data;
  logic [3:0]  ins_en;
  logic [3:0]  pad_en;
  logic        s_xfer;
  logic        m_xfer;

  sha1_sched u_sched (
    .clk   (clk),
    .ctrl  (buf_ctrl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .vars      (vars),
    .w         (w_cur),
    .rnd       (rnd),
    .vars_next (vars_next)
  );

  assign s_xfer = s_tvalid && s_tready;
  assign m_xfer = m_tvalid && m_tready;

  // byte packing helpers
  always_comb begin
    in_count  = (s_tuser > sha1_pkg::WORD_BYTES) ? sha1_pkg::WORD_BYTES : s_tuser;
    lane_off  = fill[1:0];
    room      = sha1_pkg::WORD_BYTES - {1'b0, lane_off};
    ins_k     = (rem < room) ? rem : room;
    rem_after = rem - ins_k;
    fill_ins  = fill + {3'b000, ins_k};
    fill_pad  = {fill[5:2] + 4'd1, 2'b00};
    fill_word = fill + 6'd4;
    ins_data  = (data_reg << {pos, 3'b000}) >> {lane_off, 3'b000};
    ins_en    = '0;
    pad_en    = '0;
    for (int p = 0; p < 4; p++) begin
      if (3'(p) >= {1'b0, lane_off} && 3'(p) < ({1'b0, lane_off} + ins_k)) begin
        ins_en[3 - p] = 1'b1;
      end
      if (3'(p) >= {1'b0, lane_off}) begin
        pad_en[3 - p] = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (s_xfer) begin
          if (in_count != 3'd0) begin
            state_next = sha1_pkg::ST_INS;
          end else if (s_tlast) begin
            state_next = sha1_pkg::ST_PAD80;
          end
        end
      end
      sha1_pkg::ST_INS: begin
        if (rem_after != 3'd0) begin
          ret_next = sha1_pkg::ST_INS;
        end else if (last_reg) begin
          ret_next = sha1_pkg::ST_PAD80;
        end else begin
          ret_next = sha1_pkg::ST_IDLE;
        end
        state_next = (fill_ins == 6'd0) ? sha1_pkg::ST_COMP : ret_next;
      end
      sha1_pkg::ST_PAD80: begin
        ret_next   = sha1_pkg::ST_PADZERO;
        state_next = (fill_pad == 6'd0) ? sha1_pkg::ST_COMP : sha1_pkg::ST_PADZERO;
      end
      sha1_pkg::ST_PADZERO: begin
        if (fill == sha1_pkg::LEN_FILL) begin
          state_next = sha1_pkg::ST_LEN_HI;
        end else if (fill_word == 6'd0) begin
          ret_next   = sha1_pkg::ST_PADZERO;
          state_next = sha1_pkg::ST_COMP;
        end
      end
      sha1_pkg::ST_LEN_HI: begin
        state_next = sha1_pkg::ST_LEN_LO;
      end
      sha1_pkg::ST_LEN_LO: begin
        ret_next   = sha1_pkg::ST_OUT;
        state_next = sha1_pkg::ST_COMP;
      end
      sha1_pkg::ST_COMP: begin
        if (rnd == sha1_pkg::LAST_ROUND) begin
          state_next = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: begin
        state_next = ret_state;
      end
      sha1_pkg::ST_OUT: begin
        if (m_xfer && out_idx == sha1_pkg::LAST_INDEX) begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and buffer control
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    buf_ctrl = '0;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      sha1_pkg::ST_INS: begin
        buf_ctrl.wr      = 1'b1;
        buf_ctrl.idx     = fill[5:2];
        buf_ctrl.lane_en = ins_en;
        buf_ctrl.data    = ins_data;
      end
      sha1_pkg::ST_PAD80: begin
        buf_ctrl.wr      = 1'b1;
        buf_ctrl.idx     = fill[5:2];
        buf_ctrl.lane_en = pad_en;
        buf_ctrl.data    = {sha1_pkg::PAD_BYTE, 24'd0} >> {lane_off, 3'b000};
      end
      sha1_pkg::ST_PADZERO: begin
        buf_ctrl.wr      = (fill != sha1_pkg::LEN_FILL);
        buf_ctrl.idx     = fill[5:2];
        buf_ctrl.lane_en = 4'hF;
      end
      sha1_pkg::ST_LEN_HI: begin
        buf_ctrl.wr      = 1'b1;
        buf_ctrl.idx     = sha1_pkg::LEN_HI_IDX;
        buf_ctrl.lane_en = 4'hF;
        buf_ctrl.data    = msg_bits[63:32];
      end
      sha1_pkg::ST_LEN_LO: begin
        buf_ctrl.wr      = 1'b1;
        buf_ctrl.idx     = sha1_pkg::LEN_LO_IDX;
        buf_ctrl.lane_en = 4'hF;
        buf_ctrl.data    = msg_bits[31:0];
      end
      sha1_pkg::ST_COMP: begin
        buf_ctrl.shift = 1'b1;
      end
      sha1_pkg::ST_FOLD: begin
      end
      sha1_pkg::ST_OUT: begin
        m_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (out_idx)
      3'd0:    m_tdata = chain[0];
      3'd1:    m_tdata = chain[1];
      3'd2:    m_tdata = chain[2];
      3'd3:    m_tdata = chain[3];
      default: m_tdata = chain[4];
    endcase
  end

  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == sha1_pkg::LAST_INDEX);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha1_pkg::ST_IDLE;
      ret_state <= sha1_pkg::ST_IDLE;
      chain[0]  <= sha1_pkg::IV0;
      chain[1]  <= sha1_pkg::IV1;
      chain[2]  <= sha1_pkg::IV2;
      chain[3]  <= sha1_pkg::IV3;
      chain[4]  <= sha1_pkg::IV4;
      msg_bits  <= '0;
      fill      <= '0;
      rnd       <= '0;
      rem       <= '0;
      pos       <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      unique case (state)
        sha1_pkg::ST_IDLE: begin
          if (s_xfer) begin
            rem <= in_count;
            pos <= '0;
          end
        end
        sha1_pkg::ST_INS: begin
          fill     <= fill_ins;
          rem      <= rem_after;
          pos      <= pos + ins_k;
          msg_bits <= msg_bits + {58'd0, ins_k, 3'b000};
        end
        sha1_pkg::ST_PAD80: begin
          fill <= fill_pad;
        end
        sha1_pkg::ST_PADZERO: begin
          if (fill != sha1_pkg::LEN_FILL) begin
            fill <= fill_word;
          end
        end
        sha1_pkg::ST_LEN_HI: begin
        end
        sha1_pkg::ST_LEN_LO: begin
          fill <= '0;
        end
        sha1_pkg::ST_COMP: begin
          rnd <= rnd + 7'd1;
        end
        sha1_pkg::ST_FOLD: begin
          chain[0] <= chain[0] + vars.a;
          chain[1] <= chain[1] + vars.b;
          chain[2] <= chain[2] + vars.c;
          chain[3] <= chain[3] + vars.d;
          chain[4] <= chain[4] + vars.e;
          rnd      <= '0;
        end
        sha1_pkg::ST_OUT: begin
          if (m_xfer) begin
            if (out_idx == sha1_pkg::LAST_INDEX) begin
              // restart from the initial vector for the next message
              out_idx  <= '0;
              chain[0] <= sha1_pkg::IV0;
              chain[1] <= sha1_pkg::IV1;
              chain[2] <= sha1_pkg::IV2;
              chain[3] <= sha1_pkg::IV3;
              chain[4] <= sha1_pkg::IV4;
              msg_bits <= '0;
              fill     <= '0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      data_reg <= s_tdata;
      last_reg <= s_tlast;
    end
    if (state == sha1_pkg::ST_COMP) begin
      vars <= vars_next;
    end else if (state_next == sha1_pkg::ST_COMP) begin
      // load working variables as a new block starts
      vars.a <= chain[0];
      vars.b <= chain[1];
      vars.c <= chain[2];
      vars.d <= chain[3];
      vars.e <= chain[4];
    end
  end

endmodule
